/* rtl/rmd_pkg.sv */
// rmd_pkg: shared constants and the result record of the rtsp message delimiter
// no dependencies; used by the channel interfaces and every rtl module

package rmd_pkg;

  // width of the internal length accumulator and body counter
  localparam int LEN_BITS = 32;
  // width of the body_length result field
  localparam int OUT_LEN_W = 32;
  // number of characters in "content-length:"
  localparam int KEY_LEN = 15;
  localparam int KEY_IDX_W = $clog2(KEY_LEN);

  // request op codes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_ABORT = 1'b1;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 last;
    logic                 aborted;
    logic                 length_found;
    logic [OUT_LEN_W-1:0] body_length;
  } result_t;

endpackage

/* rtl/rmd_ifs.sv */
// rmd_ifs: valid/ready channel interfaces for input bytes and framed results
// depends on rmd_pkg for the result field width

interface rmd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface rmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [7:0]                    out_byte;
  logic                          last;
  logic                          aborted;
  logic                          length_found;
  logic [rmd_pkg::OUT_LEN_W-1:0] body_length;

  modport source (output valid, output out_byte, output last, output aborted,
                  output length_found, output body_length, input ready);
  modport sink (input valid, input out_byte, input last, input aborted,
                input length_found, input body_length, output ready);
endinterface

/* rtl/rmd_parse.sv */
// rmd_parse: per-byte header scan, content-length decode and body count
// depends on rmd_pkg; state advances once per step, result is combinational

module rmd_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             op,
  input  logic [7:0]       data_byte,
  output rmd_pkg::result_t res
);

  localparam int PW = rmd_pkg::LEN_BITS + 4;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [rmd_pkg::KEY_IDX_W-1:0] KEY_LAST =
    rmd_pkg::KEY_IDX_W'(rmd_pkg::KEY_LEN - 1);

  typedef enum logic {PH_HEADER, PH_BODY} phase_t;
  typedef enum logic [1:0] {VS_SEARCH, VS_SKIP, VS_DIGITS, VS_DONE} vstage_t;

  function automatic logic [7:0] key_char(input logic [rmd_pkg::KEY_IDX_W-1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  phase_t                          phase_r, phase_nxt;
  logic [1:0]                      emc_r, emc_nxt;
  logic [rmd_pkg::KEY_IDX_W-1:0]   kidx_r, kidx_nxt;
  vstage_t                         vs_r, vs_nxt;
  logic                            seen_r, seen_nxt;
  logic                            ovf_r, ovf_nxt;
  logic [rmd_pkg::LEN_BITS-1:0]    acc_r, acc_nxt;
  logic [rmd_pkg::LEN_BITS-1:0]    rem_r, rem_nxt;

  logic [7:0]                      lc;
  logic                            is_digit;
  logic [3:0]                      dval;
  logic [PW-1:0]                   acc_ext;
  logic [PW-1:0]                   prod;
  logic [rmd_pkg::LEN_BITS-1:0]    rem_dec;
  logic                            hdr_end;
  logic                            found;

  assign lc       = (data_byte >= CH_UP_A && data_byte <= CH_UP_Z) ?
                    data_byte + CASE_OFS : data_byte;
  assign is_digit = data_byte >= CH_ZERO && data_byte <= CH_NINE;
  assign dval     = data_byte[3:0];
  // acc * 10 + digit, top nibble set means the value no longer fits
  assign acc_ext  = PW'(acc_r);
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + PW'(dval);
  assign rem_dec  = (rem_r != '0) ? rem_r - rmd_pkg::LEN_BITS'(1) : rem_r;

  always_comb begin
    phase_nxt = phase_r;
    emc_nxt   = emc_r;
    kidx_nxt  = kidx_r;
    vs_nxt    = vs_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    hdr_end   = 1'b0;
    found     = 1'b0;
    res       = '0;

    if (op == rmd_pkg::OP_ABORT) begin
      res.last    = 1'b1;
      res.aborted = 1'b1;
      phase_nxt   = PH_HEADER;
      emc_nxt     = '0;
      kidx_nxt    = '0;
      vs_nxt      = VS_SEARCH;
      seen_nxt    = 1'b0;
      ovf_nxt     = 1'b0;
      acc_nxt     = '0;
      rem_nxt     = '0;
    end else if (phase_r == PH_BODY) begin
      res.out_byte = data_byte;
      rem_nxt      = rem_dec;
      if (rem_dec == '0) begin
        res.last         = 1'b1;
        res.length_found = 1'b1;
        res.body_length  = rmd_pkg::OUT_LEN_W'(acc_r);
        phase_nxt        = PH_HEADER;
        emc_nxt          = '0;
        kidx_nxt         = '0;
        vs_nxt           = VS_SEARCH;
        seen_nxt         = 1'b0;
        ovf_nxt          = 1'b0;
        acc_nxt          = '0;
      end
    end else begin
      res.out_byte = data_byte;

      // content-length key and value tracking
      unique case (vs_r)
        VS_SEARCH: begin
          if (lc == key_char(kidx_r)) begin
            if (kidx_r == KEY_LAST) begin
              vs_nxt   = VS_SKIP;
              kidx_nxt = '0;
            end else begin
              kidx_nxt = kidx_r + rmd_pkg::KEY_IDX_W'(1);
            end
          end else begin
            kidx_nxt = (lc == key_char('0)) ? rmd_pkg::KEY_IDX_W'(1) : '0;
          end
        end
        VS_SKIP, VS_DIGITS: begin
          if (vs_r == VS_SKIP && (data_byte == CH_SP || data_byte == CH_TAB)) begin
            vs_nxt = vs_r;
          end else if (is_digit) begin
            vs_nxt   = VS_DIGITS;
            seen_nxt = 1'b1;
            if (!ovf_r) begin
              if (prod[PW-1:rmd_pkg::LEN_BITS] != '0) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = prod[rmd_pkg::LEN_BITS-1:0];
              end
            end
          end else begin
            vs_nxt = VS_DONE;
          end
        end
        default: vs_nxt = vs_r;
      endcase

      // blank line detection
      if (data_byte == CH_CR) begin
        emc_nxt = (emc_r == 2'd2) ? 2'd3 : 2'd1;
      end else if (data_byte == CH_LF) begin
        if (emc_r == 2'd1) begin
          emc_nxt = 2'd2;
        end else if (emc_r == 2'd3) begin
          hdr_end = 1'b1;
        end else begin
          emc_nxt = '0;
        end
      end else begin
        emc_nxt = '0;
      end

      if (hdr_end) begin
        found = seen_nxt && !ovf_nxt;
        if (!found || acc_nxt == '0) begin
          res.last         = 1'b1;
          res.length_found = found;
          phase_nxt        = PH_HEADER;
          emc_nxt          = '0;
          kidx_nxt         = '0;
          vs_nxt           = VS_SEARCH;
          seen_nxt         = 1'b0;
          ovf_nxt          = 1'b0;
          acc_nxt          = '0;
          rem_nxt          = '0;
        end else begin
          phase_nxt = PH_BODY;
          rem_nxt   = acc_nxt;
          emc_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      emc_r   <= '0;
      kidx_r  <= '0;
      vs_r    <= VS_SEARCH;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      emc_r   <= emc_nxt;
      kidx_r  <= kidx_nxt;
      vs_r    <= vs_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

/* rtl/rmd_out_buf.sv */
// rmd_out_buf: two-entry result register with skid so the parser keeps
// running while the receiver stalls, until both entries fill; depends on rmd_pkg

module rmd_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rmd_pkg::result_t push_res,
  output logic             full,
  output logic             out_valid,
  input  logic             out_ready,
  output rmd_pkg::result_t out_res
);

  rmd_pkg::result_t slot_r [2];
  logic             wr_r, rd_r;
  logic [1:0]       count_r, count_nxt;
  logic             pop;

  assign full      = count_r == 2'd2;
  assign out_valid = count_r != 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_res   = slot_r[rd_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_res;
    end
  end

endmodule

/* rtl/rtsp_message_delimiter_top.sv */
// rtsp_message_delimiter_top: input register, parser and result buffer
// depends on rmd_pkg, rmd_ifs, rmd_parse and rmd_out_buf
//
// usage:
//   in_ch carries one request per byte: op = data (echo the byte) or
//   op = abort (peer closed or timeout). every request yields exactly one
//   result on out_ch, in order.
//   out_ch echoes the byte with last set on the final byte of a message:
//   the last byte of the blank line when the body length is zero or absent,
//   else the last body byte. length_found and body_length are valid with last.
//   an abort yields one result with last and aborted set and restarts parsing.
// path: a request is taken into the input register, then the parser's result
//   for it is written into the result buffer, from which out_ch presents it.
// throughput: one request per cycle while out_ch does not stall; the rate is set
//   by the combinational header/body update in the parser (scan, multiply by ten and count).
// reset: rst_n low clears the parser to the header phase and empties the
//   input and result registers; no clearing pass.
// stall: the two-entry result buffer absorbs one extra result, after which
//   in_ch.ready drops until out_ch drains.

module rtsp_message_delimiter_top (
  input  logic      clk,
  input  logic      rst_n,
  rmd_in_if.sink    in_ch,
  rmd_out_if.source out_ch
);

  logic             in_v_r;
  logic             op_r;
  logic [7:0]       byte_r;
  logic             buf_full;
  logic             advance;
  logic             in_take;
  rmd_pkg::result_t step_res;
  rmd_pkg::result_t out_res;

  assign advance     = in_v_r && !buf_full;
  assign in_ch.ready = !in_v_r || !buf_full;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r   <= in_ch.op;
      byte_r <= in_ch.data_byte;
    end
  end

  rmd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .op        (op_r),
    .data_byte (byte_r),
    .res       (step_res)
  );

  rmd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_res  (step_res),
    .full      (buf_full),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.out_byte     = out_res.out_byte;
  assign out_ch.last         = out_res.last;
  assign out_ch.aborted      = out_res.aborted;
  assign out_ch.length_found = out_res.length_found;
  assign out_ch.body_length  = out_res.body_length;

endmodule
